// ===== rtl/cfdm_pkg.sv =====
// Package with the shared constants, payload types and helpers of the frequency and duty meter.
`default_nettype none

package cfdm_pkg;

    localparam int unsigned C_CLOCK_HZ   = 16000000;
    localparam int unsigned C_TIMER_SPAN = 65536;
    localparam int unsigned C_SPAN_BITS  = $clog2(C_TIMER_SPAN);
    localparam int unsigned C_CLK_BITS   = $clog2(C_CLOCK_HZ + 1);
    localparam int unsigned C_QUO_W      = (C_CLK_BITS > 24) ? C_CLK_BITS : 24;
    localparam int unsigned C_STEP_W     = $clog2(C_QUO_W);
    localparam int unsigned C_DUTY_BITS  = 7;

    localparam logic [23:0] C_FREQ_MAX  = 24'hFF_FFFF;
    localparam logic [15:0] C_COUNT_MAX = 16'hFFFF;
    localparam logic [2:0]  C_SEL_RESET = 3'd1;

    localparam logic [1:0] OP_START   = 2'd0;
    localparam logic [1:0] OP_TICK    = 2'd1;
    localparam logic [1:0] OP_CAPTURE = 2'd2;

    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_BUSY   = 2'd1;
    localparam logic [1:0] ST_BADSEL = 2'd2;
    localparam logic [1:0] ST_PERIOD = 2'd3;

    localparam logic [2:0] SEL_DIV1    = 3'd1;
    localparam logic [2:0] SEL_DIV8    = 3'd2;
    localparam logic [2:0] SEL_DIV64   = 3'd3;
    localparam logic [2:0] SEL_DIV256  = 3'd4;
    localparam logic [2:0] SEL_DIV1024 = 3'd5;

    typedef struct packed {
        logic [1:0]  op;
        logic        with_duty;
        logic [15:0] capture_time;
        logic        edge_rising;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [23:0] frequency_hz;
        logic [6:0]  duty_percent;
    } t_out_item;

    function automatic logic sel_valid(input logic [2:0] sel);
        logic ok;
        ok = 1'b0;
        case (sel) inside
            [SEL_DIV1:SEL_DIV1024]: ok = 1'b1;
            default:                ok = 1'b0;
        endcase
        return ok;
    endfunction

    function automatic logic [3:0] prescale_shift(input logic [2:0] sel);
        logic [3:0] sh;
        sh = 4'd0;
        case (sel)
            SEL_DIV1:    sh = 4'd0;
            SEL_DIV8:    sh = 4'd3;
            SEL_DIV64:   sh = 4'd6;
            SEL_DIV256:  sh = 4'd8;
            SEL_DIV1024: sh = 4'd10;
            default:     sh = 4'd0;
        endcase
        return sh;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/cfdm_in_if.sv =====
// Interface for the event channel into the meter.
`default_nettype none

interface cfdm_in_if;
    import cfdm_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/cfdm_out_if.sv =====
// Interface for the result channel out of the meter.
`default_nettype none

interface cfdm_out_if;
    import cfdm_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/capture_frequency_duty_meter.sv =====
// Top level of the input capture frequency and duty cycle meter.
//
//  Channel   Direction  Handshake          Transaction
//  i_in      in         valid/ready        start, overflow tick or capture event
//  o_out     out        valid/ready        status, frequency_hz, duty_percent
//  i_cfg     in         write enable only  clock_select register
//
// Start, tick and non-final capture events are handled directly in the idle state.
// A final rising edge runs the shared restoring divider over C_QUO_W quotient bits (24 by default)
// for the frequency and, in duty mode, over 7 more bits for the duty cycle, then emits the result.
// The input is not ready while the divider runs or while a result waits on o_out.
// Reset is synchronous and active low and returns the block to idle.
`default_nettype none

module capture_frequency_duty_meter (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [2:0] i_cfg_data,
    cfdm_in_if.sink         i_in,
    cfdm_out_if.source      o_out
);
    import cfdm_pkg::*;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'b0001,
        PH_FIRST  = 4'b0010,
        PH_FALL   = 4'b0100,
        PH_SECOND = 4'b1000
    } t_phase;

    typedef enum logic [5:0] {
        SQ_IDLE = 6'b000001,
        SQ_FREQ = 6'b000010,
        SQ_HIGH = 6'b000100,
        SQ_MUL  = 6'b001000,
        SQ_DUTY = 6'b010000,
        SQ_EMIT = 6'b100000
    } t_seq;

    logic [2:0]          r_clock_sel, n_clock_sel;
    t_phase              r_phase, n_phase;
    t_seq                r_seq, n_seq;
    logic                r_duty_mode, n_duty_mode;
    logic [15:0]         r_ovf_count, n_ovf_count;
    logic [31:0]         r_first, n_first;
    logic [31:0]         r_fall, n_fall;
    logic [31:0]         r_period, n_period;
    logic [31:0]         r_high, n_high;
    logic [C_STEP_W-1:0] r_step, n_step;
    logic [31:0]         r_rem, n_rem;
    logic [C_QUO_W-1:0]  r_num, n_num;
    logic [C_QUO_W-1:0]  r_quo, n_quo;
    logic [23:0]         r_freq, n_freq;
    logic [6:0]          r_duty, n_duty;
    logic                r_out_valid, n_out_valid;
    t_out_item           r_out_data, n_out_data;

    logic               w_ready;
    logic               w_accept;
    logic [31:0]        w_stamp;
    logic [C_QUO_W-1:0] w_freq_num;
    logic [32:0]        w_trial;
    logic               w_ge;
    logic [31:0]        w_rem_next;
    logic [C_QUO_W-1:0] w_quo_next;
    logic [23:0]        w_freq_sat;
    logic [38:0]        w_prod;
    logic [31:0]        w_high_raw;

    assign w_ready     = (r_seq == SQ_IDLE) && (!r_out_valid || o_out.ready);
    assign i_in.ready  = w_ready;
    assign w_accept    = i_in.valid && w_ready;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_data;

    assign w_stamp    = 32'({16'd0, r_ovf_count} << C_SPAN_BITS)
                        + {16'd0, i_in.data.capture_time};
    assign w_freq_num = C_QUO_W'(C_CLOCK_HZ) >> prescale_shift(r_clock_sel);

    assign w_trial    = {r_rem, r_num[C_QUO_W-1]};
    assign w_ge       = w_trial >= {1'b0, r_period};
    assign w_rem_next = w_ge ? 32'(w_trial - {1'b0, r_period}) : w_trial[31:0];
    assign w_quo_next = {r_quo[C_QUO_W-2:0], w_ge};
    assign w_freq_sat = (w_quo_next > C_QUO_W'(C_FREQ_MAX)) ? C_FREQ_MAX : w_quo_next[23:0];

    assign w_prod     = 39'(r_high) * 39'd100;
    assign w_high_raw = (r_fall >= r_first) ? (r_fall - r_first) : 32'd0;

    always_comb begin
        n_clock_sel = r_clock_sel;
        n_phase     = r_phase;
        n_seq       = r_seq;
        n_duty_mode = r_duty_mode;
        n_ovf_count = r_ovf_count;
        n_first     = r_first;
        n_fall      = r_fall;
        n_period    = r_period;
        n_high      = r_high;
        n_step      = r_step;
        n_rem       = r_rem;
        n_num       = r_num;
        n_quo       = r_quo;
        n_freq      = r_freq;
        n_duty      = r_duty;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;

        if (i_cfg_we) begin
            n_clock_sel = i_cfg_data;
        end
        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_seq)
            SQ_IDLE: begin
                if (w_accept) begin
                    case (i_in.data.op)
                        OP_START: begin
                            if (r_phase != PH_IDLE) begin
                                n_out_valid = 1'b1;
                                n_out_data  = '{ST_BUSY, 24'd0, 7'd0};
                            end else if (!sel_valid(r_clock_sel)) begin
                                n_out_valid = 1'b1;
                                n_out_data  = '{ST_BADSEL, 24'd0, 7'd0};
                            end else begin
                                n_phase     = PH_FIRST;
                                n_duty_mode = i_in.data.with_duty;
                                n_ovf_count = 16'd0;
                            end
                        end
                        OP_TICK: begin
                            if (r_phase != PH_IDLE && r_ovf_count != C_COUNT_MAX) begin
                                n_ovf_count = r_ovf_count + 16'd1;
                            end
                        end
                        OP_CAPTURE: begin
                            case (r_phase)
                                PH_FIRST: begin
                                    if (i_in.data.edge_rising) begin
                                        n_first = w_stamp;
                                        n_phase = r_duty_mode ? PH_FALL : PH_SECOND;
                                    end
                                end
                                PH_FALL: begin
                                    if (!i_in.data.edge_rising) begin
                                        n_fall  = w_stamp;
                                        n_phase = PH_SECOND;
                                    end
                                end
                                PH_SECOND: begin
                                    if (i_in.data.edge_rising) begin
                                        n_phase = PH_IDLE;
                                        if (!sel_valid(r_clock_sel)) begin
                                            n_out_valid = 1'b1;
                                            n_out_data  = '{ST_BADSEL, 24'd0, 7'd0};
                                        end else if (r_ovf_count == C_COUNT_MAX
                                                     || w_stamp <= r_first) begin
                                            n_out_valid = 1'b1;
                                            n_out_data  = '{ST_PERIOD, 24'd0, 7'd0};
                                        end else begin
                                            n_period = w_stamp - r_first;
                                            n_rem    = 32'd0;
                                            n_num    = w_freq_num;
                                            n_quo    = '0;
                                            n_step   = C_STEP_W'(C_QUO_W - 1);
                                            n_seq    = SQ_FREQ;
                                        end
                                    end
                                end
                                default: begin
                                end
                            endcase
                        end
                        default: begin
                        end
                    endcase
                end
            end
            SQ_FREQ: begin
                n_rem  = w_rem_next;
                n_num  = {r_num[C_QUO_W-2:0], 1'b0};
                n_quo  = w_quo_next;
                n_step = r_step - C_STEP_W'(1);
                if (r_step == '0) begin
                    n_freq = w_freq_sat;
                    n_duty = 7'd0;
                    n_seq  = r_duty_mode ? SQ_HIGH : SQ_EMIT;
                end
            end
            SQ_HIGH: begin
                n_high = (w_high_raw > r_period) ? r_period : w_high_raw;
                n_seq  = SQ_MUL;
            end
            SQ_MUL: begin
                n_rem  = w_prod[38:C_DUTY_BITS];
                n_num  = {w_prod[C_DUTY_BITS-1:0], {(C_QUO_W - C_DUTY_BITS){1'b0}}};
                n_quo  = '0;
                n_step = C_STEP_W'(C_DUTY_BITS - 1);
                n_seq  = SQ_DUTY;
            end
            SQ_DUTY: begin
                n_rem  = w_rem_next;
                n_num  = {r_num[C_QUO_W-2:0], 1'b0};
                n_quo  = w_quo_next;
                n_step = r_step - C_STEP_W'(1);
                if (r_step == '0) begin
                    n_duty = w_quo_next[C_DUTY_BITS-1:0];
                    n_seq  = SQ_EMIT;
                end
            end
            SQ_EMIT: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = '{ST_DONE, r_freq, r_duty};
                    n_seq       = SQ_IDLE;
                end
            end
            default: begin
                n_seq = SQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock_sel <= C_SEL_RESET;
            r_phase     <= PH_IDLE;
            r_seq       <= SQ_IDLE;
            r_duty_mode <= 1'b0;
            r_ovf_count <= 16'd0;
            r_first     <= 32'd0;
            r_fall      <= 32'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_clock_sel <= n_clock_sel;
            r_phase     <= n_phase;
            r_seq       <= n_seq;
            r_duty_mode <= n_duty_mode;
            r_ovf_count <= n_ovf_count;
            r_first     <= n_first;
            r_fall      <= n_fall;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_period   <= n_period;
        r_high     <= n_high;
        r_step     <= n_step;
        r_rem      <= n_rem;
        r_num      <= n_num;
        r_quo      <= n_quo;
        r_freq     <= n_freq;
        r_duty     <= n_duty;
        r_out_data <= n_out_data;
    end

endmodule

`default_nettype wire

// ===== tb/cfdm_checker.sv =====
`timescale 1ns / 1ps
// Checker that predicts the meter's readings from the observed transactions and compares them.
module cfdm_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_data,
    cfdm_in_if         i_in_mon,
    cfdm_out_if        i_out_mon,
    output int         o_fail_count,
    output int         o_pending
);
    import cfdm_pkg::*;

    typedef enum logic [1:0] {PH_IDLE, PH_FIRST, PH_FALL, PH_SECOND} t_meter_phase;

    t_meter_phase phase;
    logic [2:0]   clock_sel;
    logic         duty_on;
    logic [15:0]  ovf_count;
    logic [31:0]  rise_stamp;
    logic [31:0]  fall_stamp;
    t_out_item    readings[$];
    int           mismatches = 0;
    int           queued = 0;

    assign o_fail_count = mismatches;
    assign o_pending    = queued;

    function automatic int unsigned prescale_factor(input logic [2:0] sel);
        case (sel)
            SEL_DIV1:    return 1;
            SEL_DIV8:    return 8;
            SEL_DIV64:   return 64;
            SEL_DIV256:  return 256;
            SEL_DIV1024: return 1024;
            default:     return 0;
        endcase
    endfunction

    function automatic logic [31:0] stretch(input logic [15:0] ovf, input logic [15:0] t);
        return 32'(ovf) * C_TIMER_SPAN + 32'(t);
    endfunction

    task automatic push_reading(input logic [1:0] st, input logic [23:0] f, input logic [6:0] d);
        t_out_item r;
        r.status       = st;
        r.frequency_hz = f;
        r.duty_percent = d;
        readings.push_back(r);
    endtask

    task automatic close_measurement(input logic [15:0] t);
        logic [31:0]     now;
        logic [31:0]     period;
        logic [31:0]     high;
        int unsigned     pre;
        longint unsigned freq;
        longint unsigned duty;
        now   = stretch(ovf_count, t);
        pre   = prescale_factor(clock_sel);
        phase = PH_IDLE;
        if (pre == 0) begin
            push_reading(ST_BADSEL, '0, '0);
        end else if (ovf_count >= C_COUNT_MAX || now <= rise_stamp) begin
            push_reading(ST_PERIOD, '0, '0);
        end else begin
            period = now - rise_stamp;
            freq   = 64'(C_CLOCK_HZ) / (64'(pre) * 64'(period));
            if (freq > 64'(C_FREQ_MAX)) begin
                freq = 64'(C_FREQ_MAX);
            end
            duty = 0;
            if (duty_on) begin
                high = (fall_stamp >= rise_stamp) ? fall_stamp - rise_stamp : 32'd0;
                if (high > period) begin
                    high = period;
                end
                duty = (64'(high) * 64'd100) / 64'(period);
            end
            push_reading(ST_DONE, freq[23:0], duty[6:0]);
        end
    endtask

    task automatic predict_transaction(input t_in_item it);
        case (it.op)
            OP_START: begin
                if (phase != PH_IDLE) begin
                    push_reading(ST_BUSY, '0, '0);
                end else if (prescale_factor(clock_sel) == 0) begin
                    push_reading(ST_BADSEL, '0, '0);
                end else begin
                    phase     = PH_FIRST;
                    duty_on   = it.with_duty;
                    ovf_count = '0;
                end
            end
            OP_TICK: begin
                if (phase != PH_IDLE && ovf_count < C_COUNT_MAX) begin
                    ovf_count = ovf_count + 16'd1;
                end
            end
            OP_CAPTURE: begin
                case (phase)
                    PH_FIRST: begin
                        if (it.edge_rising) begin
                            rise_stamp = stretch(ovf_count, it.capture_time);
                            phase      = duty_on ? PH_FALL : PH_SECOND;
                        end
                    end
                    PH_FALL: begin
                        if (!it.edge_rising) begin
                            fall_stamp = stretch(ovf_count, it.capture_time);
                            phase      = PH_SECOND;
                        end
                    end
                    PH_SECOND: begin
                        if (it.edge_rising) begin
                            close_measurement(it.capture_time);
                        end
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
    endtask

    task automatic report_mismatch(input string field, input int unsigned want,
                                   input int unsigned got);
        $display("checker: %0s mismatch, expected %0d, got %0d, at %0t ns",
                 field, want, got, $realtime);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            phase      = PH_IDLE;
            clock_sel  = C_SEL_RESET;
            duty_on    = 1'b0;
            ovf_count  = '0;
            rise_stamp = '0;
            fall_stamp = '0;
            readings.delete();
        end else begin
            if (i_out_mon.valid && i_out_mon.ready) begin
                if (readings.size() == 0) begin
                    report_mismatch("unexpected result, status", 0, i_out_mon.data.status);
                end else begin
                    want = readings.pop_front();
                    if (i_out_mon.data.status !== want.status) begin
                        report_mismatch("status", want.status, i_out_mon.data.status);
                    end
                    if (i_out_mon.data.frequency_hz !== want.frequency_hz) begin
                        report_mismatch("frequency_hz", want.frequency_hz,
                                        i_out_mon.data.frequency_hz);
                    end
                    if (i_out_mon.data.duty_percent !== want.duty_percent) begin
                        report_mismatch("duty_percent", want.duty_percent,
                                        i_out_mon.data.duty_percent);
                    end
                end
            end
            if (i_in_mon.valid && i_in_mon.ready) begin
                predict_transaction(i_in_mon.data);
            end
            if (i_cfg_we) begin
                clock_sel = i_cfg_data;
            end
        end
        queued <= readings.size();
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Top of the testbench: clock, reset, event stimulus, result sink and the final verdict.
module testbench;
    import cfdm_pkg::*;

    logic       i_clk;
    logic       i_rst_n;
    logic       cfg_we;
    logic [2:0] cfg_data;
    logic       quiet;
    logic       hold_go;
    int         fail_count;
    int         pending;

    cfdm_in_if  in_ch ();
    cfdm_out_if out_ch ();

    capture_frequency_duty_meter u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    cfdm_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_data   (cfg_data),
        .i_in_mon     (in_ch),
        .i_out_mon    (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("testbench: FAIL");
        $finish;
    end

    // The result sink stalls in short bursts, and once holds off long enough to back up the input.
    initial begin
        int stall_left;
        int hold_left;
        bit hold_done;
        stall_left = 0;
        hold_left  = 0;
        hold_done  = 1'b0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_go && !hold_done) begin
                hold_done = 1'b1;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 5);
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    task automatic send_event(input logic [1:0] op, input logic wd, input logic [15:0] t,
                              input logic rising);
        t_in_item it;
        it.op           = op;
        it.with_duty    = wd;
        it.capture_time = t;
        it.edge_rising  = rising;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic drain_readings();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic select_clock(input logic [2:0] sel);
        drain_readings();
        repeat (40) @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_data <= sel;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_ticks(inout int counted);
        repeat ($urandom_range(0, 2)) begin
            send_event(OP_TICK, 1'($urandom), 16'($urandom), 1'($urandom));
            counted++;
        end
    endtask

    task automatic run_measurement(output int counted);
        logic wd;
        counted = 0;
        wd = 1'($urandom);
        send_event(OP_START, wd, 16'($urandom), 1'($urandom));
        counted++;
        if ($urandom_range(0, 7) == 0) begin
            send_event(OP_START, 1'($urandom), 16'($urandom), 1'($urandom));
            counted++;
        end
        if ($urandom_range(0, 5) == 0) begin
            send_event(OP_CAPTURE, 1'($urandom), 16'($urandom), 1'b0);
        end
        send_event(OP_CAPTURE, 1'($urandom), 16'($urandom), 1'b1);
        counted++;
        send_ticks(counted);
        if (wd) begin
            if ($urandom_range(0, 5) == 0) begin
                send_event(OP_CAPTURE, 1'($urandom), 16'($urandom), 1'b1);
            end
            send_event(OP_CAPTURE, 1'($urandom), 16'($urandom), 1'b0);
            counted++;
            send_ticks(counted);
        end
        if ($urandom_range(0, 5) == 0) begin
            send_event(OP_CAPTURE, 1'($urandom), 16'($urandom), 1'b0);
        end
        send_event(OP_CAPTURE, 1'($urandom), 16'($urandom), 1'b1);
        counted++;
        if ($urandom_range(0, 9) == 0) begin
            send_event(2'($urandom), 1'($urandom), 16'($urandom), 1'($urandom));
            counted++;
        end
    endtask

    initial begin
        int         counted;
        int         phase_items;
        logic [2:0] sel;
        i_rst_n     <= 1'b0;
        cfg_we      <= 1'b0;
        cfg_data    <= '0;
        in_ch.valid <= 1'b0;
        in_ch.data  <= '0;
        quiet       <= 1'b0;
        hold_go     <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Events while idle, and the unused op code, are ignored.
        send_event(OP_TICK, 1'b1, 16'hFFFF, 1'b1);
        send_event(OP_CAPTURE, 1'b0, 16'h1234, 1'b1);
        send_event(2'd3, 1'b1, 16'hFFFF, 1'b1);

        // Duty measurement with a rejected start and wrong-polarity edges in every phase.
        send_event(OP_START, 1'b1, 16'h0000, 1'b0);
        send_event(OP_START, 1'b0, 16'h0000, 1'b0);
        send_event(OP_CAPTURE, 1'b0, 16'h0010, 1'b0);
        send_event(OP_CAPTURE, 1'b0, 16'h0000, 1'b1);
        send_event(OP_CAPTURE, 1'b0, 16'h0020, 1'b1);
        send_event(OP_TICK, 1'b0, 16'h0000, 1'b0);
        send_event(OP_CAPTURE, 1'b0, 16'h8000, 1'b0);
        send_event(OP_CAPTURE, 1'b0, 16'h9000, 1'b0);
        send_event(OP_CAPTURE, 1'b0, 16'hFFFF, 1'b1);

        // Zero period, then a negative period.
        send_event(OP_START, 1'b0, 16'h0000, 1'b0);
        send_event(OP_CAPTURE, 1'b0, 16'd100, 1'b1);
        send_event(OP_CAPTURE, 1'b0, 16'd100, 1'b1);
        send_event(OP_START, 1'b0, 16'h0000, 1'b0);
        send_event(OP_CAPTURE, 1'b0, 16'd200, 1'b1);
        send_event(OP_CAPTURE, 1'b0, 16'd50, 1'b1);

        // Fall stamp before the first rise, then a high time longer than the period.
        send_event(OP_START, 1'b1, 16'h0000, 1'b0);
        send_event(OP_CAPTURE, 1'b0, 16'd1000, 1'b1);
        send_event(OP_CAPTURE, 1'b0, 16'd10, 1'b0);
        send_event(OP_CAPTURE, 1'b0, 16'd2000, 1'b1);
        send_event(OP_START, 1'b1, 16'h0000, 1'b0);
        send_event(OP_CAPTURE, 1'b0, 16'd100, 1'b1);
        send_event(OP_CAPTURE, 1'b0, 16'd1000, 1'b0);
        send_event(OP_CAPTURE, 1'b0, 16'd500, 1'b1);

        // Invalid clock selects at start, and one that appears before the final edge.
        select_clock(3'd0);
        send_event(OP_START, 1'b0, 16'h0000, 1'b0);
        select_clock(3'd7);
        send_event(OP_START, 1'b1, 16'h0000, 1'b0);
        select_clock(SEL_DIV1024);
        send_event(OP_START, 1'b0, 16'h0000, 1'b0);
        send_event(OP_CAPTURE, 1'b0, 16'd5, 1'b1);
        send_event(OP_CAPTURE, 1'b0, 16'd6, 1'b1);
        send_event(OP_START, 1'b0, 16'h0000, 1'b0);
        send_event(OP_CAPTURE, 1'b0, 16'd5, 1'b1);
        select_clock(3'd6);
        send_event(OP_CAPTURE, 1'b0, 16'd6, 1'b1);

        for (int p = 0; p < 8; p++) begin
            if (p == 0) begin
                sel = SEL_DIV1;
            end else if (p == 1) begin
                sel = SEL_DIV1024;
            end else if ($urandom_range(0, 5) == 0) begin
                sel = 3'($urandom_range(0, 7));
            end else begin
                sel = 3'($urandom_range(1, 5));
            end
            select_clock(sel);
            if (p == 2) begin
                hold_go <= 1'b1;
            end
            if (p == 7) begin
                quiet <= 1'b1;
            end
            phase_items = 0;
            while (phase_items < 131) begin
                run_measurement(counted);
                phase_items += counted;
            end
        end

        drain_readings();
        repeat (50) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

// ===== capture_frequency_duty_meter.f =====
rtl/cfdm_pkg.sv
rtl/cfdm_in_if.sv
rtl/cfdm_out_if.sv
rtl/capture_frequency_duty_meter.sv
tb/cfdm_checker.sv
tb/testbench.sv
